// File: design/pli_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the piecewise linear interpolator.
// No dependencies; pli_muldiv and the interpolator import this package.
package pli_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int DATA_W = 32;
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int QUOT_W = 40;
  localparam int SUM_W  = QUOT_W + 2;
  localparam int PC_W   = 7;
  localparam int STAT_W = 2;
  localparam int STEP_W = 7;

  localparam logic [PC_W-1:0] PC_RESET = 7'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_W = 2'd2;

  localparam logic signed [DATA_W-1:0] Y_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Y_MIN = 32'sh8000_0000;

  localparam logic [STEP_W-1:0] MUL_LAST = 7'(DIFF_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = 7'(PROD_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DIFF,
    ST_CHECK,
    ST_WAIT,
    ST_SUM,
    ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic big;
  } md_status_t;

endpackage

// File: design/pli_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/pli_muldiv.sv
`timescale 1ns / 1ps
// Bit-serial |a*b|/|d| unit: shift-add multiply, then restoring divide,
// both on one shared adder. Depends on pli_pkg.
module pli_muldiv (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [pli_pkg::DIFF_W-1:0]     a,
  input  logic signed [pli_pkg::DIFF_W-1:0]     b,
  input  logic signed [pli_pkg::DIFF_W-1:0]     d,
  output logic        [pli_pkg::QUOT_W-1:0]     quot,
  output pli_pkg::md_status_t                   stat
);
  import pli_pkg::*;

  md_state_t           state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [DIFF_W-1:0]   ma_r, ma_nxt;
  logic [DIFF_W-1:0]   md_r, md_nxt;
  logic [DIFF_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;

  logic [DIFF_W:0]     rsh;
  logic [DIFF_W+1:0]   op_a, op_b, alu_sum;
  logic                alu_cin;
  logic                ge;
  logic [DIFF_W-1:0]   mag_a, mag_b, mag_d;

  assign mag_a = a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
  assign mag_b = b[DIFF_W-1] ? DIFF_W'(-b) : DIFF_W'(b);
  assign mag_d = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);

  assign rsh = {rem_r, prod_r[PROD_W-1]};

  always_comb begin
    if (state_r == MD_DIV) begin
      op_a    = {1'b0, rsh};
      op_b    = ~{2'b00, md_r};
      alu_cin = 1'b1;
    end else begin
      op_a    = {2'b00, prod_r[PROD_W-1:DIFF_W]};
      op_b    = {2'b00, ma_r};
      alu_cin = 1'b0;
    end
    alu_sum = op_a + op_b + (DIFF_W + 2)'(alu_cin);
  end

  assign ge = ~alu_sum[DIFF_W+1];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    ma_nxt    = ma_r;
    md_nxt    = md_r;
    rem_nxt   = rem_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      MD_IDLE: begin
        if (start) begin
          ma_nxt    = mag_a;
          md_nxt    = mag_d;
          prod_nxt  = {{DIFF_W{1'b0}}, mag_b};
          cnt_nxt   = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        if (prod_r[0]) begin
          prod_nxt = {alu_sum[DIFF_W:0], prod_r[DIFF_W-1:1]};
        end else begin
          prod_nxt = {1'b0, prod_r[PROD_W-1:1]};
        end
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_nxt  = ge ? alu_sum[DIFF_W-1:0] : rsh[DIFF_W-1:0];
        prod_nxt = {prod_r[PROD_W-2:0], ge};
        cnt_nxt  = cnt_r + STEP_W'(1);
        if (cnt_r == DIV_LAST) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    md_r   <= md_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
  end

  assign quot      = prod_r[QUOT_W-1:0];
  assign stat.busy = (state_r != MD_IDLE);
  assign stat.done = done_r;
  assign stat.big  = |prod_r[PROD_W-1:QUOT_W];

endmodule

// File: design/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// Load: writes the entry at in_point_index when it is in range. Query: k = index of the
// first entry at or above the query; the scan reads entries 0 to k at one table read per
// cycle, then the 33-step multiply and 66-step divide run on the shared adder of pli_muldiv.
// One item at a time; the finished result waits in the output register.
// Reset clears control, sets point_count to 2; table contents stay undefined.
// Depends on pli_pkg, pli_ram and pli_muldiv.
module piecewise_linear_interpolator #(
  parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pli_pkg::PC_W-1:0]            cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [5:0]                          in_point_index,
  input  logic signed [pli_pkg::DATA_W-1:0]   in_x_value,
  input  logic signed [pli_pkg::DATA_W-1:0]   in_y_value,
  input  logic                                in_batch_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pli_pkg::DATA_W-1:0]   out_y_result,
  output logic [pli_pkg::STAT_W-1:0]          out_status,
  output logic                                out_batch_end_out
);
  import pli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  st_t                       state_r, state_nxt;
  logic [PC_W-1:0]           pc_r;
  logic [AW-1:0]             adv_r, adv_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic                      lo_first_r, lo_first_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic signed [DATA_W-1:0]  qx_r, qx_nxt;
  logic                      be_r, be_nxt;
  logic signed [DATA_W-1:0]  x0_r, x0_nxt, y0_r, y0_nxt;
  logic signed [DATA_W-1:0]  x1_r, x1_nxt, y1_r, y1_nxt;
  logic signed [DIFF_W-1:0]  dy_r, dy_nxt, dxq_r, dxq_nxt, dxs_r, dxs_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [DATA_W-1:0]  res_r, res_nxt;
  logic [STAT_W-1:0]         stat_r, stat_nxt;
  logic signed [DATA_W-1:0]  out_y_r, out_y_nxt;
  logic [STAT_W-1:0]         out_stat_r, out_stat_nxt;
  logic                      out_be_r, out_be_nxt;

  logic                      in_acc;
  logic                      wr_en;
  logic [AW-1:0]             rd_addr;
  logic [2*DATA_W-1:0]       rd_data;
  logic signed [DATA_W-1:0]  ram_x, ram_y;
  logic [31:0]               pc32;
  logic [CW-1:0]             n_sel;
  logic [CW-1:0]             adv_inc;
  logic                      md_start;
  logic [QUOT_W-1:0]         md_quot;
  md_status_t                md_stat;
  logic signed [SUM_W-1:0]   y0_ext, q_ext, sum_ext;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && (in_command == CMD_LOAD)
                    && (32'(in_point_index) < 32'(TABLE_DEPTH));
  assign ram_x    = rd_data[DATA_W-1:0];
  assign ram_y    = rd_data[2*DATA_W-1:DATA_W];

  pli_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_point_index)),
    .wr_data ({in_y_value, in_x_value}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pli_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (dy_r),
    .b     (dxq_r),
    .d     (dxs_r),
    .quot  (md_quot),
    .stat  (md_stat)
  );

  always_comb begin
    pc32 = 32'(pc_r);
    if (pc32 < 32'd2) begin
      n_sel = CW'(2);
    end else if (pc32 > 32'(TABLE_DEPTH)) begin
      n_sel = CW'(TABLE_DEPTH);
    end else begin
      n_sel = CW'(pc_r);
    end
    adv_inc = CW'(adv_r) + CW'(1);
    y0_ext  = SUM_W'(y0_r);
    q_ext   = SUM_W'(md_quot);
    sum_ext = neg_r ? (y0_ext - q_ext) : (y0_ext + q_ext);
  end

  always_comb begin
    state_nxt     = state_r;
    adv_nxt       = adv_r;
    n_nxt         = n_r;
    lo_first_nxt  = lo_first_r;
    out_valid_nxt = out_valid_r;
    qx_nxt        = qx_r;
    be_nxt        = be_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    dy_nxt        = dy_r;
    dxq_nxt       = dxq_r;
    dxs_nxt       = dxs_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_y_nxt     = out_y_r;
    out_stat_nxt  = out_stat_r;
    out_be_nxt    = out_be_r;
    rd_addr       = '0;
    md_start      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_command == CMD_QUERY)) begin
          qx_nxt    = in_x_value;
          be_nxt    = in_batch_end;
          n_nxt     = n_sel;
          adv_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ram_x >= qx_r) begin
          lo_first_nxt = (adv_r == '0);
          if (adv_r == '0) begin
            x0_nxt  = ram_x;
            y0_nxt  = ram_y;
            rd_addr = AW'(1);
          end else begin
            x1_nxt  = ram_x;
            y1_nxt  = ram_y;
            rd_addr = adv_r - AW'(1);
          end
          state_nxt = ST_FETCH;
        end else if (adv_inc >= n_r) begin
          res_nxt   = '0;
          stat_nxt  = STAT_RANGE;
          state_nxt = ST_OUT;
        end else begin
          rd_addr = AW'(adv_inc);
          adv_nxt = AW'(adv_inc);
        end
      end
      ST_FETCH: begin
        if (lo_first_r) begin
          x1_nxt = ram_x;
          y1_nxt = ram_y;
        end else begin
          x0_nxt = ram_x;
          y0_nxt = ram_y;
        end
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        dy_nxt    = DIFF_W'(y1_r) - DIFF_W'(y0_r);
        dxq_nxt   = DIFF_W'(qx_r) - DIFF_W'(x0_r);
        dxs_nxt   = DIFF_W'(x1_r) - DIFF_W'(x0_r);
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (dxs_r == '0) begin
          res_nxt   = '0;
          stat_nxt  = STAT_ZERO_W;
          state_nxt = ST_OUT;
        end else begin
          md_start  = 1'b1;
          neg_nxt   = dy_r[DIFF_W-1] ^ dxq_r[DIFF_W-1] ^ dxs_r[DIFF_W-1];
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_stat.done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (md_stat.big) begin
          res_nxt = neg_r ? Y_MIN : Y_MAX;
        end else if (sum_ext > SUM_W'(Y_MAX)) begin
          res_nxt = Y_MAX;
        end else if (sum_ext < SUM_W'(Y_MIN)) begin
          res_nxt = Y_MIN;
        end else begin
          res_nxt = DATA_W'(sum_ext);
        end
        stat_nxt  = STAT_OK;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = res_r;
          out_stat_nxt  = stat_r;
          out_be_nxt    = be_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= PC_RESET;
      adv_r       <= '0;
      n_r         <= CW'(2);
      lo_first_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      adv_r       <= adv_nxt;
      n_r         <= n_nxt;
      lo_first_r  <= lo_first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    qx_r       <= qx_nxt;
    be_r       <= be_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    dy_r       <= dy_nxt;
    dxq_r      <= dxq_nxt;
    dxs_r      <= dxs_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_y_r    <= out_y_nxt;
    out_stat_r <= out_stat_nxt;
    out_be_r   <= out_be_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_y_result      = out_y_r;
  assign out_status        = out_stat_r;
  assign out_batch_end_out = out_be_r;

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_LOAD)) |=> (state_r == ST_IDLE))
    else $error("load item left the idle state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CW'(adv_r) < n_r))
    else $error("scan index past active entries");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_y_result == '0))
    else $error("error item carries nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == STAT_OK) || (out_status == STAT_RANGE)
                   || (out_status == STAT_ZERO_W)))
    else $error("undefined status code");

  a_wait_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> (md_stat.busy || md_stat.done))
    else $error("waiting on idle multiply-divide unit");

endmodule
